[hw/rtl/tlprq_pkg.sv]
// ----------------------------------------------------------------------------
// tlprq_pkg
// Types and codes shared by the two-level priority ready queue scheduler.
// ----------------------------------------------------------------------------
package tlprq_pkg;

  localparam int ID_W = 4;
  localparam int OP_W = 3;
  localparam int STAT_W = 3;
  localparam int ID_SPAN = 1 << ID_W;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_YIELD = 3'd1;
  localparam logic [OP_W-1:0] OP_WAKEUP = 3'd2;
  localparam logic [OP_W-1:0] OP_BLOCK = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NONE = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 3'd4;

  localparam logic [1:0] TS_READY = 2'd0;
  localparam logic [1:0] TS_RUNNING = 2'd1;
  localparam logic [1:0] TS_BLOCKED = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] thread_id;
    logic            is_low_priority;
  } tlprq_in_t;

  typedef struct packed {
    logic              current_valid;
    logic [ID_W-1:0]   current_id;
    logic              current_low;
    logic [STAT_W-1:0] status;
  } tlprq_out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD,
    CMD_WAKE,
    CMD_BLOCK,
    CMD_REQUEUE,
    CMD_POP,
    CMD_TAKE,
    CMD_CLEAR_CUR,
    CMD_SCAN_START_HI,
    CMD_SCAN_START_LO,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_SCAN_END,
    CMD_OUT
  } cmd_code_t;

  typedef enum logic [1:0] {
    TBL_ID,
    TBL_RID,
    TBL_RDATA
  } tbl_src_t;

  typedef struct packed {
    cmd_code_t         code;
    tbl_src_t          tbl_src;
    logic              st_en;
    logic [STAT_W-1:0] st_val;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;
    logic            rv;
    logic            is_cur;
    logic            ts_blocked;
    logic            hi_ne;
    logic            lo_ne;
    logic            scan_more;
    logic            scan_low;
    logic            found;
  } dp_stat_t;

endpackage

[hw/rtl/tlprq_ram.sv]
// ----------------------------------------------------------------------------
// tlprq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlprq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tlprq_dp.sv]
// ----------------------------------------------------------------------------
// tlprq_dp
// Datapath: ready queues, pointers, thread table, current thread, result.
// ----------------------------------------------------------------------------
module tlprq_dp #(
  parameter int THREAD_COUNT = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tlprq_pkg::tlprq_in_t  req,
  input  tlprq_pkg::ctl_cmd_t   cmd,
  output tlprq_pkg::dp_stat_t   stat,
  output tlprq_pkg::tlprq_out_t rsp
);

  import tlprq_pkg::*;

  localparam int TBL = (THREAD_COUNT < ID_SPAN) ? THREAD_COUNT : ID_SPAN;
  localparam int TW = $clog2(TBL);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = QW + 1;
  localparam int IW1 = ID_W + 1;
  localparam logic [IW1-1:0] TBL_C = IW1'(TBL);
  localparam logic [CW-1:0] FULL_C = CW'(QUEUE_DEPTH);

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  function automatic logic [QW-1:0] ptr_add(input logic [QW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[QW-1:0];
  endfunction

  logic [OP_W-1:0]   in_op;
  logic [ID_W-1:0]   in_id;
  logic              in_low;
  logic [QW-1:0]     head_hi;
  logic [QW-1:0]     head_lo;
  logic [CW-1:0]     cnt_hi;
  logic [CW-1:0]     cnt_lo;
  logic              rv;
  logic [ID_W-1:0]   rid;
  logic [1:0]        tstate [TBL];
  logic              tlow [TBL];
  logic              qsel;
  logic [QW-1:0]     rd_ptr;
  logic [QW-1:0]     wr_ptr;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     kept;
  logic              found;
  logic [STAT_W-1:0] st;

  logic [ID_W-1:0] rdata_hi;
  logic [ID_W-1:0] rdata_lo;
  logic [ID_W-1:0] q_rdata;
  logic [ID_W-1:0] tbl_a;
  logic            tbl_hit;
  logic [TW-1:0]   tbl_idx;
  logic [1:0]      ts_rd;
  logic            tl_rd;
  logic            push_req;
  logic            push_low;
  logic            push_full;
  logic            scan_keep;
  logic            we_hi;
  logic            we_lo;
  logic [QW-1:0]   waddr_hi;
  logic [QW-1:0]   waddr_lo;
  logic [ID_W-1:0] wdata;
  logic [QW-1:0]   raddr;
  logic            rdata_ok;
  logic            hi_ne;
  logic            lo_ne;

  assign q_rdata = qsel ? rdata_lo : rdata_hi;
  assign hi_ne = (cnt_hi != '0);
  assign lo_ne = (cnt_lo != '0);

  always_comb begin
    case (cmd.tbl_src)
      TBL_ID:    tbl_a = in_id;
      TBL_RID:   tbl_a = rid;
      TBL_RDATA: tbl_a = q_rdata;
      default:   tbl_a = rid;
    endcase
  end

  assign tbl_hit = (IW1'(tbl_a) < TBL_C);
  assign tbl_idx = tbl_a[TW-1:0];
  assign ts_rd = tbl_hit ? tstate[tbl_idx] : TS_READY;
  assign tl_rd = tbl_hit ? tlow[tbl_idx] : 1'b0;
  assign rdata_ok = (IW1'(q_rdata) < TBL_C);

  assign push_req = (cmd.code == CMD_ADD) || (cmd.code == CMD_WAKE) ||
                    ((cmd.code == CMD_REQUEUE) && rv && (ts_rd == TS_RUNNING));
  assign push_low = (cmd.code == CMD_ADD) ? in_low : tl_rd;
  assign push_full = push_low ? (cnt_lo == FULL_C) : (cnt_hi == FULL_C);
  assign scan_keep = (cmd.code == CMD_SCAN_CHK) && (q_rdata != in_id);

  assign we_hi = (push_req && !push_low && !push_full) || (scan_keep && !qsel);
  assign we_lo = (push_req && push_low && !push_full) || (scan_keep && qsel);
  assign waddr_hi = (cmd.code == CMD_SCAN_CHK) ? wr_ptr : ptr_add(head_hi, cnt_hi);
  assign waddr_lo = (cmd.code == CMD_SCAN_CHK) ? wr_ptr : ptr_add(head_lo, cnt_lo);
  assign wdata = (cmd.code == CMD_SCAN_CHK) ? q_rdata : tbl_a;
  assign raddr = (cmd.code == CMD_POP) ? (hi_ne ? head_hi : head_lo) : rd_ptr;

  tlprq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_high_queue (
    .clk   (clk),
    .we    (we_hi),
    .waddr (waddr_hi),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_hi)
  );

  tlprq_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_low_queue (
    .clk   (clk),
    .we    (we_lo),
    .waddr (waddr_lo),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_lo)
  );

  always_ff @(posedge clk) begin
    if (cmd.code == CMD_LOAD) begin
      in_op <= req.operation;
      in_id <= req.thread_id;
      in_low <= req.is_low_priority;
    end
    if (cmd.code == CMD_OUT) begin
      rsp.current_valid <= rv;
      rsp.current_id <= rv ? rid : '0;
      rsp.current_low <= rv & tl_rd;
      rsp.status <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_hi <= '0;
      head_lo <= '0;
      cnt_hi <= '0;
      cnt_lo <= '0;
      rv <= 1'b0;
      rid <= '0;
      for (int i = 0; i < TBL; i++) begin
        tstate[i] <= TS_READY;
        tlow[i] <= 1'b0;
      end
      qsel <= 1'b0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      idx <= '0;
      kept <= '0;
      found <= 1'b0;
      st <= STAT_OK;
    end else begin
      if (push_req) begin
        if (push_full) begin
          st <= STAT_FULL;
        end else if (push_low) begin
          cnt_lo <= cnt_lo + CW'(1);
        end else begin
          cnt_hi <= cnt_hi + CW'(1);
        end
      end
      if (cmd.st_en) begin
        st <= cmd.st_val;
      end
      case (cmd.code)
        CMD_LOAD: begin
          st <= STAT_OK;
        end
        CMD_ADD: begin
          if (tbl_hit) begin
            tlow[tbl_idx] <= in_low;
          end
        end
        CMD_WAKE: begin
          if (tbl_hit) begin
            tstate[tbl_idx] <= TS_READY;
          end
        end
        CMD_BLOCK: begin
          if (tbl_hit) begin
            tstate[tbl_idx] <= TS_BLOCKED;
          end
        end
        CMD_REQUEUE: begin
          if (rv && tbl_hit && (ts_rd == TS_RUNNING)) begin
            tstate[tbl_idx] <= TS_READY;
          end
        end
        CMD_POP: begin
          qsel <= !hi_ne;
          if (hi_ne) begin
            head_hi <= ptr_inc(head_hi);
            cnt_hi <= cnt_hi - CW'(1);
          end else begin
            head_lo <= ptr_inc(head_lo);
            cnt_lo <= cnt_lo - CW'(1);
          end
        end
        CMD_TAKE: begin
          if (rdata_ok) begin
            rv <= 1'b1;
            rid <= q_rdata;
            if (tbl_hit) begin
              tstate[tbl_idx] <= TS_RUNNING;
            end
          end else begin
            rv <= 1'b0;
            rid <= '0;
          end
        end
        CMD_CLEAR_CUR: begin
          rv <= 1'b0;
          rid <= '0;
        end
        CMD_SCAN_START_HI: begin
          qsel <= 1'b0;
          rd_ptr <= head_hi;
          wr_ptr <= head_hi;
          idx <= '0;
          kept <= '0;
          found <= 1'b0;
        end
        CMD_SCAN_START_LO: begin
          qsel <= 1'b1;
          rd_ptr <= head_lo;
          wr_ptr <= head_lo;
          idx <= '0;
          kept <= '0;
          found <= 1'b0;
        end
        CMD_SCAN_RD: begin
          rd_ptr <= ptr_inc(rd_ptr);
          idx <= idx + CW'(1);
        end
        CMD_SCAN_CHK: begin
          if (scan_keep) begin
            wr_ptr <= ptr_inc(wr_ptr);
            kept <= kept + CW'(1);
          end else begin
            found <= 1'b1;
          end
        end
        CMD_SCAN_END: begin
          if (qsel) begin
            cnt_lo <= kept;
          end else begin
            cnt_hi <= kept;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.op = in_op;
  assign stat.id_ok = (IW1'(in_id) < TBL_C);
  assign stat.rv = rv;
  assign stat.is_cur = rv && (rid == in_id);
  assign stat.ts_blocked = (ts_rd == TS_BLOCKED);
  assign stat.hi_ne = hi_ne;
  assign stat.lo_ne = lo_ne;
  assign stat.scan_more = (idx < (qsel ? cnt_lo : cnt_hi));
  assign stat.scan_low = qsel;
  assign stat.found = found;

endmodule

[hw/rtl/tlprq_ctrl.sv]
// ----------------------------------------------------------------------------
// tlprq_ctrl
// Controller: sequences one request through the datapath, owns handshakes.
// ----------------------------------------------------------------------------
module tlprq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  tlprq_pkg::dp_stat_t stat,
  output tlprq_pkg::ctl_cmd_t cmd
);

  import tlprq_pkg::*;

  typedef enum logic [8:0] {
    CS_IDLE     = 9'b000000001,
    CS_EXEC     = 9'b000000010,
    CS_POP      = 9'b000000100,
    CS_TAKE     = 9'b000001000,
    CS_SCAN_RD  = 9'b000010000,
    CS_SCAN_CHK = 9'b000100000,
    CS_SCAN_END = 9'b001000000,
    CS_SCAN_LO  = 9'b010000000,
    CS_DONE     = 9'b100000000
  } ctl_state_t;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       out_load;

  assign req_ready = (state == CS_IDLE);
  assign out_load = (cmd.code == CMD_OUT);

  always_comb begin
    state_next = state;
    cmd.code = CMD_NONE;
    cmd.tbl_src = TBL_RID;
    cmd.st_en = 1'b0;
    cmd.st_val = STAT_OK;
    case (state)
      CS_IDLE: begin
        if (req_valid) begin
          cmd.code = CMD_LOAD;
          state_next = CS_EXEC;
        end
      end
      CS_EXEC: begin
        state_next = CS_DONE;
        case (stat.op)
          OP_ADD: begin
            cmd.tbl_src = TBL_ID;
            if (stat.id_ok) begin
              cmd.code = CMD_ADD;
            end else begin
              cmd.st_en = 1'b1;
              cmd.st_val = STAT_IGNORED;
            end
          end
          OP_YIELD: begin
            cmd.code = CMD_REQUEUE;
            state_next = CS_POP;
          end
          OP_WAKEUP: begin
            cmd.tbl_src = TBL_ID;
            if (stat.id_ok && stat.ts_blocked) begin
              cmd.code = CMD_WAKE;
            end else begin
              cmd.st_en = 1'b1;
              cmd.st_val = STAT_IGNORED;
            end
          end
          OP_BLOCK: begin
            if (stat.rv) begin
              cmd.code = CMD_BLOCK;
            end else begin
              cmd.st_en = 1'b1;
              cmd.st_val = STAT_IGNORED;
            end
          end
          OP_REMOVE: begin
            cmd.tbl_src = TBL_ID;
            if (!stat.id_ok) begin
              cmd.st_en = 1'b1;
              cmd.st_val = STAT_IGNORED;
            end else if (stat.is_cur) begin
              cmd.code = CMD_CLEAR_CUR;
            end else begin
              cmd.code = CMD_SCAN_START_HI;
              state_next = CS_SCAN_RD;
            end
          end
          default: begin
            cmd.st_en = 1'b1;
            cmd.st_val = STAT_IGNORED;
          end
        endcase
      end
      CS_POP: begin
        if (stat.hi_ne || stat.lo_ne) begin
          cmd.code = CMD_POP;
          state_next = CS_TAKE;
        end else begin
          cmd.code = CMD_CLEAR_CUR;
          cmd.st_en = 1'b1;
          cmd.st_val = STAT_NONE;
          state_next = CS_DONE;
        end
      end
      CS_TAKE: begin
        cmd.code = CMD_TAKE;
        cmd.tbl_src = TBL_RDATA;
        state_next = CS_DONE;
      end
      CS_SCAN_RD: begin
        if (stat.scan_more) begin
          cmd.code = CMD_SCAN_RD;
          state_next = CS_SCAN_CHK;
        end else begin
          state_next = CS_SCAN_END;
        end
      end
      CS_SCAN_CHK: begin
        cmd.code = CMD_SCAN_CHK;
        state_next = CS_SCAN_RD;
      end
      CS_SCAN_END: begin
        cmd.code = CMD_SCAN_END;
        if (stat.found) begin
          state_next = CS_DONE;
        end else if (stat.scan_low) begin
          cmd.st_en = 1'b1;
          cmd.st_val = STAT_NOTFOUND;
          state_next = CS_DONE;
        end else begin
          state_next = CS_SCAN_LO;
        end
      end
      CS_SCAN_LO: begin
        cmd.code = CMD_SCAN_START_LO;
        state_next = CS_SCAN_RD;
      end
      CS_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.code = CMD_OUT;
          state_next = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/two_level_priority_ready_queues.sv]
// ----------------------------------------------------------------------------
// two_level_priority_ready_queues
// Strict-priority thread scheduler with high and low FIFO ready queues.
// ----------------------------------------------------------------------------
// req carries one scheduling request a beat (add, yield, wakeup, block,
// remove); rsp returns one beat per request with the current thread and a
// status code. Both channels are valid/ready.
// Requests run one at a time. Add, wakeup, block and unknown codes pass
// through the execute and done states. Yield requeues the current thread,
// pops a queue and takes the registered RAM read; with both queues empty it
// clears the current thread instead. Remove of a valid id that is not the
// current thread walks the live entries of the high queue, then the low
// queue if the id was not there, with a read and a check state per entry
// and an end state per queue walked. The next request is taken the cycle
// after the result is loaded into the output register.
// A result waiting on rsp_ready does not block the next request from being
// taken; that request finishes once the output register frees up.
// Reset empties both queues, clears the current thread and sets every
// thread ready and high priority; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_level_priority_ready_queues #(
  parameter int THREAD_COUNT = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  tlprq_pkg::tlprq_in_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output tlprq_pkg::tlprq_out_t rsp
);

  import tlprq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  tlprq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlprq_dp #(
    .THREAD_COUNT (THREAD_COUNT),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

[verif/two_level_priority_ready_queues_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_priority_ready_queues_tb
// Self-checking bench for the strict-priority two-level ready queue scheduler.
// A scoreboard keeps its own copy of the thread table, both FIFOs and the
// current thread, predicts the response of every accepted request beat and
// compares each response beat field by field in order. Stimulus is a short
// directed pass followed by random sequences (mixed traffic, queue floods,
// drains) with random idling on both channels.
// ----------------------------------------------------------------------------
module two_level_priority_ready_queues_tb;
  import tlprq_pkg::*;

  class sched_scoreboard;
    localparam int THREADS = 16;
    localparam int DEPTH = 16;

    logic [ID_W-1:0]   fifo[2][DEPTH];
    int unsigned       head[2];
    int unsigned       fill[2];
    logic              cur_valid;
    logic [ID_W-1:0]   cur_id;
    logic [1:0]        state_of[THREADS];
    logic              low_of[THREADS];
    tlprq_out_t        outcome_q[$];
    int unsigned       fails;

    function new();
      head = '{0, 0};
      fill = '{0, 0};
      cur_valid = 1'b0;
      cur_id = '0;
      for (int t = 0; t < THREADS; t++) begin
        state_of[t] = TS_READY;
        low_of[t] = 1'b0;
      end
      fails = 0;
    endfunction

    function bit push_thread(logic [ID_W-1:0] id);
      int q;
      q = low_of[id] ? 1 : 0;
      if (fill[q] >= DEPTH) return 1'b0;
      fifo[q][(head[q] + fill[q]) % DEPTH] = id;
      fill[q]++;
      return 1'b1;
    endfunction

    function logic [ID_W-1:0] pop_thread(int q);
      logic [ID_W-1:0] id;
      id = fifo[q][head[q]];
      head[q] = (head[q] + 1) % DEPTH;
      fill[q]--;
      return id;
    endfunction

    function bit strip_thread(int q, logic [ID_W-1:0] id);
      int unsigned kept;
      bit found;
      logic [ID_W-1:0] v;
      kept = 0;
      found = 1'b0;
      for (int unsigned i = 0; i < fill[q]; i++) begin
        v = fifo[q][(head[q] + i) % DEPTH];
        if (v == id) begin
          found = 1'b1;
        end else begin
          fifo[q][(head[q] + kept) % DEPTH] = v;
          kept++;
        end
      end
      fill[q] = kept;
      return found;
    endfunction

    function tlprq_out_t apply_request(tlprq_in_t r);
      tlprq_out_t o;
      logic [STAT_W-1:0] st;
      bit id_ok;
      bit found;
      st = STAT_OK;
      id_ok = int'(r.thread_id) < THREADS;
      case (r.operation)
        OP_ADD: begin
          if (!id_ok) begin
            st = STAT_IGNORED;
          end else begin
            low_of[r.thread_id] = r.is_low_priority;
            if (!push_thread(r.thread_id)) st = STAT_FULL;
          end
        end
        OP_YIELD: begin
          if (cur_valid && state_of[cur_id] == TS_RUNNING) begin
            state_of[cur_id] = TS_READY;
            if (!push_thread(cur_id)) st = STAT_FULL;
          end
          if (fill[0] > 0) begin
            cur_id = pop_thread(0);
            cur_valid = 1'b1;
            state_of[cur_id] = TS_RUNNING;
          end else if (fill[1] > 0) begin
            cur_id = pop_thread(1);
            cur_valid = 1'b1;
            state_of[cur_id] = TS_RUNNING;
          end else begin
            cur_valid = 1'b0;
            cur_id = '0;
            st = STAT_NONE;
          end
        end
        OP_WAKEUP: begin
          if (!id_ok || state_of[r.thread_id] != TS_BLOCKED) begin
            st = STAT_IGNORED;
          end else begin
            state_of[r.thread_id] = TS_READY;
            if (!push_thread(r.thread_id)) st = STAT_FULL;
          end
        end
        OP_BLOCK: begin
          if (cur_valid) state_of[cur_id] = TS_BLOCKED;
          else st = STAT_IGNORED;
        end
        OP_REMOVE: begin
          if (!id_ok) begin
            st = STAT_IGNORED;
          end else if (cur_valid && cur_id == r.thread_id) begin
            cur_valid = 1'b0;
            cur_id = '0;
          end else begin
            found = strip_thread(0, r.thread_id);
            if (!found) found = strip_thread(1, r.thread_id);
            if (!found) st = STAT_NOTFOUND;
          end
        end
        default: st = STAT_IGNORED;
      endcase
      o.current_valid = cur_valid;
      o.current_id = cur_valid ? cur_id : '0;
      o.current_low = cur_valid ? low_of[cur_id] : 1'b0;
      o.status = st;
      return o;
    endfunction

    function void note_request(tlprq_in_t r);
      outcome_q = {outcome_q, apply_request(r)};
    endfunction

    function void flag(string what, int exp_v, int act_v);
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
    endfunction

    function void check_response(tlprq_out_t act);
      tlprq_out_t exp_o;
      if (outcome_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected response beat, expected none, actual %h", $time, act);
        return;
      end
      exp_o = outcome_q.pop_front();
      if (act.current_valid !== exp_o.current_valid)
        flag("current_valid", exp_o.current_valid, act.current_valid);
      if (act.current_id !== exp_o.current_id)
        flag("current_id", exp_o.current_id, act.current_id);
      if (act.current_low !== exp_o.current_low)
        flag("current_low", exp_o.current_low, act.current_low);
      if (act.status !== exp_o.status)
        flag("status", exp_o.status, act.status);
    endfunction

    function int unsigned waiting();
      return outcome_q.size();
    endfunction

    function logic [ID_W-1:0] some_blocked();
      logic [ID_W-1:0] picks[$];
      for (int t = 0; t < THREADS; t++)
        if (state_of[t] == TS_BLOCKED) picks = {picks, t[ID_W-1:0]};
      if (picks.size() == 0) return ID_W'($urandom_range(0, THREADS - 1));
      return picks[$urandom_range(0, picks.size() - 1)];
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 80;
  localparam int RANDOM_ITEMS = 800;
  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_C = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  tlprq_in_t  req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  tlprq_out_t rsp;

  sched_scoreboard sb;
  bit steady = 1'b0;
  int unsigned sent = 0;
  int unsigned cycles = 0;

  two_level_priority_ready_queues u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("two_level_priority_ready_queues_tb failed");
      $finish;
    end
  end

  task automatic send_req(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic low);
    int gap;
    tlprq_in_t beat;
    beat.operation = op;
    beat.thread_id = id;
    beat.is_low_priority = low;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= beat;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(beat);
    sent++;
  endtask

  task automatic hold_until_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.waiting() != 0) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, 15));
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic mix_seq();
    int n;
    int pick;
    n = $urandom_range(6, 12);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) send_req(OP_ADD, any_id(), coin());
      else if (pick < 55) send_req(OP_YIELD, any_id(), coin());
      else if (pick < 70) send_req(OP_WAKEUP, coin() ? sb.some_blocked() : any_id(), coin());
      else if (pick < 80) send_req(OP_BLOCK, any_id(), coin());
      else if (pick < 95) send_req(OP_REMOVE, coin() ? sb.cur_id : any_id(), coin());
      else send_req(OP_W'($urandom_range(OP_UNUSED_A, OP_UNUSED_C)), any_id(), coin());
    end
  endtask

  // overfill one queue, then requeue and wake into it
  task automatic flood_seq(logic low);
    int n;
    n = $urandom_range(17, 20);
    repeat (n) send_req(OP_ADD, any_id(), low);
    send_req(OP_YIELD, any_id(), coin());
    send_req(OP_YIELD, any_id(), coin());
    send_req(OP_BLOCK, any_id(), coin());
    repeat (2) send_req(OP_ADD, any_id(), low);
    send_req(OP_WAKEUP, sb.cur_id, coin());
    send_req(OP_YIELD, any_id(), coin());
  endtask

  task automatic drain_seq();
    int n;
    n = $urandom_range(8, 20);
    repeat (n) begin
      if (coin()) send_req(OP_YIELD, any_id(), coin());
      else send_req(OP_REMOVE, any_id(), coin());
    end
  endtask

  initial begin : rsp_sink
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      sb.check_response(rsp);
    end
  end

  initial begin : stimulus
    int kind;
    int base;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed pass
    send_req(OP_YIELD, 4'd0, 1'b0);
    send_req(OP_BLOCK, 4'd0, 1'b0);
    send_req(OP_WAKEUP, 4'd4, 1'b0);
    send_req(OP_REMOVE, 4'd7, 1'b1);
    send_req(OP_UNUSED_A, 4'd15, 1'b1);
    send_req(OP_UNUSED_B, 4'd10, 1'b0);
    send_req(OP_UNUSED_C, 4'd5, 1'b1);
    send_req(OP_ADD, 4'd0, 1'b0);
    send_req(OP_ADD, 4'd15, 1'b1);
    send_req(OP_ADD, 4'd9, 1'b0);
    send_req(OP_YIELD, 4'd15, 1'b1);
    send_req(OP_YIELD, 4'd0, 1'b0);
    send_req(OP_BLOCK, 4'd0, 1'b0);
    send_req(OP_YIELD, 4'd0, 1'b0);
    send_req(OP_WAKEUP, 4'd9, 1'b0);
    send_req(OP_REMOVE, 4'd15, 1'b0);
    send_req(OP_ADD, 4'd6, 1'b1);
    send_req(OP_ADD, 4'd6, 1'b1);
    send_req(OP_REMOVE, 4'd6, 1'b0);
    send_req(OP_REMOVE, 4'd0, 1'b0);
    send_req(OP_REMOVE, 4'd0, 1'b1);
    send_req(OP_YIELD, 4'd0, 1'b0);
    send_req(OP_ADD, 4'd3, 1'b1);
    send_req(OP_YIELD, 4'd0, 1'b0);
    send_req(OP_REMOVE, 4'd3, 1'b0);
    hold_until_drained();

    flood_seq(1'b0);
    drain_seq();
    flood_seq(1'b1);
    drain_seq();

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 7) mix_seq();
      else if (kind == 7) flood_seq(coin());
      else drain_seq();
      if ($urandom_range(0, 7) == 0) hold_until_drained();
    end
    steady = 1'b0;

    req_valid <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.waiting() == 0) begin
      $display("two_level_priority_ready_queues_tb passed");
    end else begin
      $display("two_level_priority_ready_queues_tb failed");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/tlprq_pkg.sv
hw/rtl/tlprq_ram.sv
hw/rtl/tlprq_dp.sv
hw/rtl/tlprq_ctrl.sv
hw/rtl/two_level_priority_ready_queues.sv
verif/two_level_priority_ready_queues_tb.sv
